>>> sv/fsha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsha_pkg
// Shared types and constants of the fit-strategy hole allocator.
// ----------------------------------------------------------------------------
package fsha_pkg;

	localparam int MAX_HOLES   = 16;
	localparam int HOLE_IDX_W  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int SIZE_W      = 16;
	localparam int SUM_W       = 20;
	localparam int SLOT_W      = 4;
	localparam int COUNT_W     = 5;
	localparam int STRAT_W     = 2;
	localparam int SEL_W       = (HOLE_IDX_W > COUNT_W) ? HOLE_IDX_W : COUNT_W;
	localparam int PICK_EXT_W  = (HOLE_IDX_W > SLOT_W) ? HOLE_IDX_W : SLOT_W;

	localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
	localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
	localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

	localparam logic [1:0] REG_STRATEGY     = 2'd0;
	localparam logic [1:0] REG_HOLES_IN_USE = 2'd1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	typedef struct packed {
		logic                  valid;
		logic                  found;
		logic [HOLE_IDX_W-1:0] pick;
		logic [SIZE_W-1:0]     pick_size;
		logic [SUM_W-1:0]      sum;
	} scan_pkt_t;

	typedef struct packed {
		logic                  load_en;
		logic [SLOT_W-1:0]     load_slot;
		logic [SIZE_W-1:0]     load_value;
		logic                  dec_en;
		logic [HOLE_IDX_W-1:0] dec_slot;
		logic [SIZE_W-1:0]     amount;
		logic [STRAT_W-1:0]    strategy;
		logic [COUNT_W-1:0]    holes_in_use;
	} cell_ctl_t;

endpackage

>>> sv/fit_strategy_hole_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_strategy_hole_allocator_top
// Hole table allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel. A load request (tuser 0) writes one
// hole size and completes in the cycle it is taken; it gives no result.
// An allocate request (tuser 1) sends a scan packet down a chain of
// MAX_HOLES cells, one cell per cycle, then writes its result to the m_axis
// output register and shrinks the chosen hole in the same cycle.
// An allocate request passes through launch_q, the cells in order and res_q
// before its result is written; no new request is accepted until the block
// is idle again.
// The cfg channel writes register 0 (strategy) or 1 (holes_in_use), is always
// ready; the user must write it only while the block is idle (unchecked).
// Reset clears all hole sizes, selects first fit and sixteen holes in use.
// When the receiver stalls, the finished result waits in the output
// register and new requests are still taken; a later allocate request holds
// its scan result until the register is free, and no request is taken while
// it waits.
// ----------------------------------------------------------------------------
module fit_strategy_hole_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // hole_slot[3:0], amount[19:4], zero pad
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // chosen_hole[3:0], free_total[23:4]
	output logic        m_axis_tuser,  // granted
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import fsha_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [STRAT_W-1:0]   strategy_q;
	logic [COUNT_W-1:0]   holes_in_use_q;
	logic [SIZE_W-1:0]    amount_q;
	scan_pkt_t            launch_q;
	scan_pkt_t            res_q;
	scan_pkt_t            chain [MAX_HOLES+1];
	cell_ctl_t            ctl;
	logic                 in_acc;
	logic                 out_free;
	logic                 finish;
	logic [PICK_EXT_W-1:0] pick_ext;
	logic [SUM_W-1:0]     free_total;
	logic                 m_valid_q;
	logic                 m_user_q;
	logic [23:0]          m_data_q;

	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign finish        = (state_q == ST_DONE) && out_free;

	assign ctl.load_en      = in_acc && (s_axis_tuser == OP_LOAD);
	assign ctl.load_slot    = s_axis_tdata[3:0];
	assign ctl.load_value   = s_axis_tdata[19:4];
	assign ctl.dec_en       = finish && res_q.found;
	assign ctl.dec_slot     = res_q.pick;
	assign ctl.amount       = amount_q;
	assign ctl.strategy     = strategy_q;
	assign ctl.holes_in_use = holes_in_use_q;

	assign chain[0] = launch_q;

	for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
		fsha_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (HOLE_IDX_W'(i)),
			.ctl      (ctl),
			.pkt_in   (chain[i]),
			.pkt_out  (chain[i+1])
		);
	end

	assign pick_ext   = res_q.found ? PICK_EXT_W'(res_q.pick) : '0;
	assign free_total = res_q.found ? (res_q.sum - SUM_W'(amount_q)) : res_q.sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			strategy_q     <= STRAT_FIRST;
			holes_in_use_q <= COUNT_W'(16);
			launch_q       <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			launch_q <= '{valid: in_acc && (s_axis_tuser == OP_ALLOC), found: 1'b0,
				pick: '0, pick_size: '0, sum: '0};
			m_valid_q <= finish || (m_valid_q && !m_axis_tready);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_STRATEGY) begin
					strategy_q <= cfg_data[STRAT_W-1:0];
				end else if (cfg_index == REG_HOLES_IN_USE) begin
					holes_in_use_q <= cfg_data;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == OP_ALLOC)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain[MAX_HOLES].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (s_axis_tuser == OP_ALLOC)) begin
			amount_q <= s_axis_tdata[19:4];
		end
		if ((state_q == ST_SCAN) && chain[MAX_HOLES].valid) begin
			res_q <= chain[MAX_HOLES];
		end
		if (finish) begin
			m_user_q <= res_q.found;
			m_data_q <= {free_total, pick_ext[SLOT_W-1:0]};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tdata  = m_data_q;

endmodule

>>> sv/fsha_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsha_cell
// One hole of the table: holds its size, folds it into the passing scan
// packet and hands the packet on to the next cell.
// ----------------------------------------------------------------------------
module fsha_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [fsha_pkg::HOLE_IDX_W-1:0] cell_idx,
	input  fsha_pkg::cell_ctl_t            ctl,
	input  fsha_pkg::scan_pkt_t            pkt_in,
	output fsha_pkg::scan_pkt_t            pkt_out
);
	import fsha_pkg::*;

	logic [SIZE_W-1:0] size_q;
	scan_pkt_t         pkt_q;
	scan_pkt_t         pkt_nxt;
	logic              active;
	logic              take;
	logic              is_best;
	logic              is_worst;

	assign active   = SEL_W'(cell_idx) < SEL_W'(ctl.holes_in_use);
	assign is_best  = ctl.strategy == STRAT_BEST;
	assign is_worst = ctl.strategy == STRAT_WORST;

	always_comb begin
		take = active && (size_q >= ctl.amount) &&
			(!pkt_in.found ||
			 (is_best && (size_q < pkt_in.pick_size)) ||
			 (is_worst && (size_q > pkt_in.pick_size)));
		pkt_nxt = pkt_in;
		if (active) begin
			pkt_nxt.sum = pkt_in.sum + SUM_W'(size_q);
		end
		if (take) begin
			pkt_nxt.found     = 1'b1;
			pkt_nxt.pick      = cell_idx;
			pkt_nxt.pick_size = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			pkt_q  <= '0;
		end else begin
			pkt_q <= pkt_nxt;
			if (ctl.load_en && (SEL_W'(ctl.load_slot) == SEL_W'(cell_idx))) begin
				size_q <= ctl.load_value;
			end else if (ctl.dec_en && (ctl.dec_slot == cell_idx)) begin
				size_q <= size_q - ctl.amount;
			end
		end
	end

	assign pkt_out = pkt_q;

endmodule
